// ===== rtl/c2p_pkg.sv =====
// shared constants, types and angle table for the cartesian-to-polar pipeline
package c2p_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int STAGES      = 16;
    localparam int GUARD_SHIFT = 60 - DATA_WIDTH;
    localparam int TABLE_LEN   = 32;

    // x/y datapath width: input plus negation, cordic gain and guard bits
    localparam int XY_W    = DATA_WIDTH + GUARD_SHIFT + 2;
    localparam int SUM_W   = 2 * DATA_WIDTH;
    localparam int REM_W   = DATA_WIDTH + 1;
    localparam int N_CELLS = (STAGES > DATA_WIDTH) ? STAGES : DATA_WIDTH;
    localparam int SHIFT_W = (N_CELLS > 1) ? $clog2(N_CELLS) : 1;

    // +pi/2 and -pi/2 as binary angles
    localparam logic [DATA_WIDTH-1:0] PHASE_POS_QUARTER = {2'b01, {(DATA_WIDTH-2){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] PHASE_NEG_QUARTER = {2'b11, {(DATA_WIDTH-2){1'b0}}};
    localparam logic [31:0]           ACC_HALF_TURN     = 32'h8000_0000;

    // atan(2^-i), 2^32 per full turn
    localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // payload handed from cell to cell
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [31:0]            acc;
        logic [SUM_W-1:0]       rad;
        logic [REM_W-1:0]       rem;
        logic [DATA_WIDTH-1:0]  root;
        logic                   re_zero;
        logic                   im_pos;
    } cell_t;

endpackage

// ===== rtl/cartesian_to_polar_top.sv =====
// top level of the cartesian-to-polar converter
//
// converts one complex sample (real_part, imag_part) into its rounded magnitude
// and its phase as a binary angle, 32768 per pi, with +pi wrapping to -32768
//
// input: a transfer happens on each rising edge with start high and busy low;
//   busy is held low, so a new sample may be sent on every clock
// output: done is high for exactly one cycle with magnitude and phase valid
//   in that cycle; the receiver takes it then and cannot stall the block
// path: an input transfer passes through two front-end stages, one cell per
//   cordic rotation / root digit and one result stage, which raises done
// throughput: one sample per clock, set by the cell chain, where every cell
//   holds a different sample and hands it to its neighbor each cycle
// zero real part: phase is +pi/2 for a positive imaginary part, -pi/2 for
//   anything else including the origin
// reset: clears the valid pipe; samples in flight are dropped and no done
//   pulse comes out for them
module cartesian_to_polar_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0]  real_part,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0]  imag_part,
    output logic                                   done,
    output logic [c2p_pkg::DATA_WIDTH-1:0]         magnitude,
    output logic signed [c2p_pkg::DATA_WIDTH-1:0]  phase
);
    import c2p_pkg::*;

    localparam int LATENCY = N_CELLS + 3;

    // valid and payload along the chain, index 0 is the front-end output
    logic  vld_chain  [N_CELLS+1];
    cell_t cell_chain [N_CELLS+1];
    logic  accept;

    // fully pipelined, never refuses a sample
    assign busy   = 1'b0;
    assign accept = start && !busy;

    c2p_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld_in    (accept),
        .real_part (real_part),
        .imag_part (imag_part),
        .vld_out   (vld_chain[0]),
        .cell_out  (cell_chain[0])
    );

    generate
        for (genvar k = 0; k < N_CELLS; k++)
        begin : g_cell
            // rotations past STAGES or TABLE_LEN add no angle; digits past DATA_WIDTH pass through
            localparam logic [31:0] ANGLE = (k < STAGES && k < TABLE_LEN) ? ATAN_TAB[k] : '0;

            c2p_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (SHIFT_W'(k)),
                .angle    (ANGLE),
                .root_en  (k < DATA_WIDTH),
                .vld_in   (vld_chain[k]),
                .cell_in  (cell_chain[k]),
                .vld_out  (vld_chain[k+1]),
                .cell_out (cell_chain[k+1])
            );
        end
    endgenerate

    c2p_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld_in    (vld_chain[N_CELLS]),
        .cell_in   (cell_chain[N_CELLS]),
        .done      (done),
        .magnitude (magnitude),
        .phase     (phase)
    );

    // every accepted sample is followed by its done pulse
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted sample produced no done pulse");

    // no done pulse without a matching transfer
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("done pulse without an accepted sample");

    // origin gives zero magnitude and -pi/2
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(accept && real_part == '0 && imag_part == '0, LATENCY)
        |-> magnitude == '0 && phase == $signed(PHASE_NEG_QUARTER))
        else $error("origin result wrong");

    // negative real axis wraps to -pi
    a_neg_axis: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(accept && real_part[DATA_WIDTH-1] && imag_part == '0, LATENCY)
        |-> phase == $signed({1'b1, {(DATA_WIDTH-1){1'b0}}}))
        else $error("negative real axis phase wrong");

endmodule

// ===== rtl/c2p_prep.sv =====
// front end: half-plane fold, squares, radicand and cordic seed
module c2p_prep (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   vld_in,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0]  real_part,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0]  imag_part,
    output logic                                   vld_out,
    output c2p_pkg::cell_t                         cell_out
);
    import c2p_pkg::*;

    localparam int DW = DATA_WIDTH;

    logic                 s1_vld_reg;
    logic signed [DW:0]   s1_x_reg, s1_y_reg;
    logic [SUM_W-1:0]     s1_sq_re_reg, s1_sq_im_reg;
    logic                 s1_half_reg, s1_re_zero_reg, s1_im_pos_reg;

    logic                 s2_vld_reg;
    cell_t                s2_cell_reg;

    logic signed [DW:0]   re_ext, im_ext, x_next, y_next;
    logic [DW-1:0]        are, aim;
    logic                 re_neg;
    cell_t                s2_next;

    always_comb
    begin
        re_ext = {real_part[DW-1], real_part};
        im_ext = {imag_part[DW-1], imag_part};
        re_neg = real_part[DW-1];
        // left half plane rotates by pi first
        x_next = re_neg ? -re_ext : re_ext;
        y_next = re_neg ? -im_ext : im_ext;
        are    = x_next[DW-1:0];
        aim    = imag_part[DW-1] ? DW'(-im_ext) : DW'(im_ext);
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg       <= x_next;
        s1_y_reg       <= y_next;
        s1_sq_re_reg   <= SUM_W'(are) * SUM_W'(are);
        s1_sq_im_reg   <= SUM_W'(aim) * SUM_W'(aim);
        s1_half_reg    <= re_neg;
        s1_re_zero_reg <= (real_part == '0);
        s1_im_pos_reg  <= !imag_part[DW-1] && (imag_part != '0);
    end

    always_comb
    begin
        s2_next.x       = {{(XY_W-DW-1-GUARD_SHIFT){s1_x_reg[DW]}}, s1_x_reg,
                           {GUARD_SHIFT{1'b0}}};
        s2_next.y       = {{(XY_W-DW-1-GUARD_SHIFT){s1_y_reg[DW]}}, s1_y_reg,
                           {GUARD_SHIFT{1'b0}}};
        s2_next.acc     = s1_half_reg ? ACC_HALF_TURN : '0;
        s2_next.rad     = s1_sq_re_reg + s1_sq_im_reg;
        s2_next.rem     = '0;
        s2_next.root    = '0;
        s2_next.re_zero = s1_re_zero_reg;
        s2_next.im_pos  = s1_im_pos_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_cell_reg <= s2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= vld_in;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    assign vld_out  = s2_vld_reg;
    assign cell_out = s2_cell_reg;

endmodule

// ===== rtl/c2p_cell.sv =====
// one pipeline cell: a cordic micro-rotation and, with root_en, one square-root digit
module c2p_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [c2p_pkg::SHIFT_W-1:0]   shift,
    input  logic [31:0]                   angle,
    input  logic                          root_en,
    input  logic                          vld_in,
    input  c2p_pkg::cell_t                cell_in,
    output logic                          vld_out,
    output c2p_pkg::cell_t                cell_out
);
    import c2p_pkg::*;

    localparam int DW = DATA_WIDTH;

    logic signed [XY_W-1:0] xs, ys;
    logic [REM_W+1:0]       trial_rem, trial;
    logic                   take;
    cell_t                  cell_next;
    cell_t                  cell_reg;
    logic                   vld_reg;

    always_comb
    begin
        xs = $signed(cell_in.x) >>> shift;
        ys = $signed(cell_in.y) >>> shift;

        trial_rem = {cell_in.rem, cell_in.rad[SUM_W-1 -: 2]};
        trial     = (REM_W+2)'({cell_in.root, 2'b01});
        take      = (trial_rem >= trial);

        cell_next = cell_in;
        // rotate toward the x axis
        if (!cell_in.y[XY_W-1])
        begin
            cell_next.x   = cell_in.x + ys;
            cell_next.y   = cell_in.y - xs;
            cell_next.acc = cell_in.acc + angle;
        end
        else
        begin
            cell_next.x   = cell_in.x - ys;
            cell_next.y   = cell_in.y + xs;
            cell_next.acc = cell_in.acc - angle;
        end
        // restoring square-root digit
        if (root_en)
        begin
            cell_next.rad  = cell_in.rad << 2;
            cell_next.rem  = take ? REM_W'(trial_rem - trial) : REM_W'(trial_rem);
            cell_next.root = {cell_in.root[DW-2:0], take};
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    assign vld_out  = vld_reg;
    assign cell_out = cell_reg;

endmodule

// ===== rtl/c2p_post.sv =====
// back end: rounding of magnitude and phase, zero-real rule, result register
module c2p_post (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   vld_in,
    input  c2p_pkg::cell_t                         cell_in,
    output logic                                   done,
    output logic [c2p_pkg::DATA_WIDTH-1:0]         magnitude,
    output logic signed [c2p_pkg::DATA_WIDTH-1:0]  phase
);
    import c2p_pkg::*;

    localparam int DW = DATA_WIDTH;

    logic [DW-1:0] mag_next, mag_reg;
    logic [DW-1:0] cordic_phase, phase_next, phase_reg;
    logic          done_reg;

    generate
        if (DW < 32)
        begin : g_round
            logic [31:0] acc_rnd;
            assign acc_rnd      = cell_in.acc + (32'd1 << (31 - DW));
            assign cordic_phase = acc_rnd[31 -: DW];
        end
        else
        begin : g_full
            assign cordic_phase = cell_in.acc[DW-1:0];
        end
    endgenerate

    always_comb
    begin
        // rem = s - root^2, round up when it exceeds root
        mag_next = cell_in.root + DW'(cell_in.rem > REM_W'(cell_in.root));
        if (cell_in.re_zero)
            phase_next = cell_in.im_pos ? PHASE_POS_QUARTER : PHASE_NEG_QUARTER;
        else
            phase_next = cordic_phase;
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        phase_reg <= phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_in;
    end

    assign done      = done_reg;
    assign magnitude = mag_reg;
    assign phase     = phase_reg;

endmodule

// ===== tb/tb_top.sv =====
// testbench for the cartesian-to-polar converter: self-checking, predictor-based
`timescale 1ns / 1ps

module tb_top;

    localparam int DW = c2p_pkg::DATA_WIDTH;

    // input transfer to done, as stated for the block, plus a little slack
    localparam int LATENCY = c2p_pkg::N_CELLS + 3;
    localparam int SETTLE  = LATENCY + 8;

    // a correct run ends well before this, so this only catches a hang
    localparam longint TIMEOUT_NS = 64'd4_000_000;

    localparam int RANDOM_PER_PHASE = 450;

    typedef logic signed [DW-1:0] sample_t;

    // one expected result: rounded magnitude and binary-angle phase
    typedef struct packed {
        logic [DW-1:0]        mag;
        logic signed [DW-1:0] ang;
    } polar_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    sample_t real_part;
    sample_t imag_part;
    logic    done;
    logic [DW-1:0] magnitude;
    sample_t phase;

    // expected results, oldest first
    polar_t expected_polar [$];

    int samples_sent    = 0;
    int results_checked = 0;
    int mismatches      = 0;

    cartesian_to_polar_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .real_part (real_part),
        .imag_part (imag_part),
        .done      (done),
        .magnitude (magnitude),
        .phase     (phase)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // exact rounded square root of re^2 + im^2 and a 16-stage vectoring
    // cordic for the phase, with the zero-real-part rule on top
    function automatic polar_t polar_of(sample_t re, sample_t im);
        longint          are;
        longint          aim;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned rem;
        longint unsigned digit;
        longint          x;
        longint          y;
        longint          xs;
        longint          ys;
        logic [31:0]     acc;
        logic [32:0]     wide;
        polar_t          p;

        are = (re < 0) ? -longint'(re) : longint'(re);
        aim = (im < 0) ? -longint'(im) : longint'(im);
        sq  = longint'(are * are + aim * aim);

        // digit-by-digit root, then round up when the remainder exceeds root
        root  = 0;
        rem   = sq;
        digit = 64'h4000_0000_0000_0000;
        while (digit > sq)
            digit = digit >> 2;
        while (digit != 0)
        begin
            if (rem >= root + digit)
            begin
                rem  = rem - (root + digit);
                root = (root >> 1) + digit;
            end
            else
            begin
                root = root >> 1;
            end
            digit = digit >> 2;
        end
        if (rem > root)
            root = root + 1;
        p.mag = root[DW-1:0];

        if (re == 0)
        begin
            // imaginary axis and origin: only a positive im gives +pi/2
            p.ang = (im > 0) ? c2p_pkg::PHASE_POS_QUARTER : c2p_pkg::PHASE_NEG_QUARTER;
        end
        else
        begin
            // left half plane is folded over by a half turn
            if (re < 0)
            begin
                x   = -longint'(re);
                y   = -longint'(im);
                acc = c2p_pkg::ACC_HALF_TURN;
            end
            else
            begin
                x   = longint'(re);
                y   = longint'(im);
                acc = 32'd0;
            end
            x = x * (longint'(1) <<< c2p_pkg::GUARD_SHIFT);
            y = y * (longint'(1) <<< c2p_pkg::GUARD_SHIFT);
            for (int i = 0; i < c2p_pkg::STAGES && i < c2p_pkg::TABLE_LEN; i++)
            begin
                // arithmetic shift of a signed value floors, as required
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x   = x + ys;
                    y   = y - xs;
                    acc = acc + c2p_pkg::ATAN_TAB[i];
                end
                else
                begin
                    x   = x - ys;
                    y   = y + xs;
                    acc = acc - c2p_pkg::ATAN_TAB[i];
                end
            end
            // round 32-bit angle to nearest; +pi wraps to -32768 on its own
            wide  = {1'b0, acc} + (33'd1 << (31 - DW));
            p.ang = wide[31:32-DW];
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one input transfer; before it the sender idles each cycle with the
    // given chance in percent, and start stays high between back-to-back items
    task automatic send_sample(input sample_t re, input sample_t im, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        real_part <= re;
        imag_part <= im;
        @(posedge clk);
        // busy as sampled at this edge decides whether the transfer happened
        while (busy)
            @(posedge clk);
        expected_polar.push_back(polar_of(re, im));
        samples_sent++;
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (expected_polar.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // random samples: half of them full range, with extra weight on small values,
    // the two axes and full-scale corners where rounding and wrap are touchy
    task automatic run_random(input int count, input int idle_pct);
        sample_t re;
        sample_t im;
        int      kind;

        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(9);
            case (kind)
                5, 6:
                begin
                    re = sample_t'(int'($urandom_range(128)) - 64);
                    im = sample_t'(int'($urandom_range(128)) - 64);
                end
                7:
                begin
                    re = '0;
                    im = ($urandom_range(1) != 0) ? sample_t'($urandom)
                                                  : sample_t'(int'($urandom_range(4)) - 2);
                end
                8:
                begin
                    re = sample_t'($urandom);
                    im = '0;
                end
                9:
                begin
                    re = ($urandom_range(1) != 0) ? sample_t'(16'h8000) : sample_t'(16'h7FFF);
                    im = sample_t'($urandom);
                    if ($urandom_range(1) != 0)
                    begin
                        re = im;
                        im = ($urandom_range(1) != 0) ? sample_t'(16'h8000)
                                                      : sample_t'(16'h7FFF);
                    end
                end
                default:
                begin
                    re = sample_t'($urandom);
                    im = sample_t'($urandom);
                end
            endcase
            send_sample(re, im, idle_pct);
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // corners: origin, both axes both ways, full scale, the +pi wrap,
    // near-axis points and a few simple diagonals
    task automatic test_corners();
        sample_t corner_re [] = '{
            16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
            16'sd1, -16'sd1, 16'sd32767, -16'sd32768, -16'sd5,
            -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
            -16'sd32768, -16'sd32768, 16'sd1, -16'sd1, -16'sd1, 16'sd1,
            16'sd32767, -16'sd32767, 16'sd100, 16'sd3
        };
        sample_t corner_im [] = '{
            16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768,
            16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
            -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
            16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1,
            -16'sd1, 16'sd32767, -16'sd32768, 16'sd4
        };

        for (int k = 0; k < corner_re.size(); k++)
            send_sample(corner_re[k], corner_im[k], 20);
        drain_results();
    endtask

    // full rate, a new sample every clock
    task automatic test_back_to_back();
        run_random(RANDOM_PER_PHASE, 0);
    endtask

    // sender mostly idle, so gaps land on every pipeline stage
    task automatic test_sparse_sender();
        run_random(RANDOM_PER_PHASE, 87);
    endtask

    // moderate idling, bursts mixed with short gaps
    task automatic test_mixed_idle();
        run_random(RANDOM_PER_PHASE, 32);
    endtask

    // ------------------------------------------------------------------
    // result checking: every done pulse against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        polar_t want;

        if (rst_n && done)
        begin
            if (expected_polar.size() == 0)
            begin
                $display("%0t: unexpected result magnitude %0d phase %0d",
                         $time, magnitude, phase);
                mismatches++;
            end
            else
            begin
                want = expected_polar.pop_front();
                results_checked++;
                if (magnitude !== want.mag)
                begin
                    $display("%0t: magnitude mismatch expected %0d actual %0d",
                             $time, want.mag, magnitude);
                    mismatches++;
                end
                if (phase !== want.ang)
                begin
                    $display("%0t: phase mismatch expected %0d actual %0d",
                             $time, want.ang, phase);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        real_part = '0;
        imag_part = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        test_back_to_back();
        test_sparse_sender();
        test_mixed_idle();

        // nothing more to send; let the pipe empty out
        start <= 1'b0;
        while (expected_polar.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d samples: corners, axes, full scale, pi wrap, random at full rate",
                 samples_sent);
        $display("and with an idle sender; %0d results checked, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0 && expected_polar.size() == 0)
            $display("PASS cartesian_to_polar_top");
        else
            $display("FAIL cartesian_to_polar_top");
        $finish;
    end

    // hang guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", expected_polar.size());
        $display("FAIL cartesian_to_polar_top");
        $finish;
    end

endmodule
